// File: hdl/etpr_pkg.sv
// ---------------------------------------------------------------------------
// Event trigger pulse repeater: shared definitions
// Widths, register indexes, status codes and the bundles passed between the
// step logic and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package etpr_pkg;

   localparam int CountWidth  = 17;
   localparam int PeriodWidth = 17;
   localparam int CmpWidth    = (CountWidth > PeriodWidth) ? CountWidth : PeriodWidth;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = PeriodWidth;
   localparam int ReqDataWidth = 8;
   localparam int RspDataWidth = 8;
   localparam int StatusWidth  = 2;

   localparam logic [CsrAddrWidth-1:0] RegInvertValue  = 3'd0;
   localparam logic [CsrAddrWidth-1:0] RegTapMode      = 3'd1;
   localparam logic [CsrAddrWidth-1:0] RegLevelMode    = 3'd2;
   localparam logic [CsrAddrWidth-1:0] RegRepeatOnHigh = 3'd3;
   localparam logic [CsrAddrWidth-1:0] RegRepeatOnLow  = 3'd4;
   localparam logic [CsrAddrWidth-1:0] RegRepeatPeriod = 3'd5;

   localparam logic [StatusWidth-1:0] StatusOff      = 2'd0;
   localparam logic [StatusWidth-1:0] StatusRising   = 2'd1;
   localparam logic [StatusWidth-1:0] StatusHeld     = 2'd2;
   localparam logic [StatusWidth-1:0] StatusFalling  = 2'd3;

   typedef struct packed {
      logic                   invert_value;
      logic                   tap_mode;
      logic                   level_mode;
      logic                   repeat_on_high;
      logic                   repeat_on_low;
      logic [PeriodWidth-1:0] repeat_period;
   } cfg_type;

   typedef struct packed {
      logic                  level_now;
      logic                  level_before;
      logic [CountWidth-1:0] high_tick_count;
      logic [CountWidth-1:0] low_tick_count;
   } state_type;

   typedef struct packed {
      logic                   enabled;
      logic                   event_seen;
      logic                   value_nonzero;
   } item_type;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic                   positive;
      logic                   catch_up;
      logic                   fire;
   } result_type;

endpackage

`default_nettype wire

// File: hdl/etpr_step.sv
// ---------------------------------------------------------------------------
// Event trigger pulse repeater: tick step
// Next level, repeat counters and result for one tick, from the current
// state, the configuration and the incoming item.
// ---------------------------------------------------------------------------
`default_nettype none

module etpr_step
   import etpr_pkg::*;
(
   input  wire cfg_type    cfg,
   input  wire state_type  state_cur,
   input  wire item_type   item,
   output state_type       state_nxt,
   output result_type      result
);

   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   logic [CountWidth-1:0] high_inc;
   logic [CountWidth-1:0] low_inc;
   logic                  high_over;
   logic                  low_over;
   logic                  level_in;
   logic                  fire;
   logic                  catch_up;

   // saturating increment, then compare against the period
   always_comb begin
      high_inc  = (state_cur.high_tick_count != CountMax) ?
                  state_cur.high_tick_count + 1'b1 : state_cur.high_tick_count;
      low_inc   = (state_cur.low_tick_count != CountMax) ?
                  state_cur.low_tick_count + 1'b1 : state_cur.low_tick_count;
      high_over = CmpWidth'(high_inc) > CmpWidth'(cfg.repeat_period);
      low_over  = CmpWidth'(low_inc) > CmpWidth'(cfg.repeat_period);
   end

   always_comb begin
      state_nxt = state_cur;
      fire      = 1'b0;
      catch_up  = 1'b0;
      level_in  = item.value_nonzero ^ cfg.invert_value;
      if (item.enabled) begin
         state_nxt.level_before = state_cur.level_now;
         state_nxt.level_now    = level_in;
         if (item.event_seen) begin
            if (level_in || !cfg.tap_mode) begin
               fire                      = 1'b1;
               state_nxt.high_tick_count = '0;
               state_nxt.low_tick_count  = '0;
            end
         end else begin
            if (cfg.repeat_on_high) begin
               state_nxt.high_tick_count = high_over ? '0 : high_inc;
               if (high_over && level_in) begin
                  fire = 1'b1;
               end
            end
            if (cfg.repeat_on_low && !cfg.tap_mode) begin
               state_nxt.low_tick_count = low_over ? '0 : low_inc;
               if (low_over && !level_in) begin
                  fire = 1'b1;
               end
            end
         end
         // tap: falling pulse after a positive tick, level forced off
         if (cfg.tap_mode && !fire) begin
            fire                = state_cur.level_now;
            state_nxt.level_now = 1'b0;
         end
         catch_up = !fire && cfg.level_mode;
      end
   end

   always_comb begin
      result.fire     = fire;
      result.catch_up = catch_up;
      result.positive = state_nxt.level_now;
      unique case ({state_nxt.level_now, state_nxt.level_before})
         2'b10:   result.status = StatusRising;
         2'b11:   result.status = StatusHeld;
         2'b01:   result.status = StatusFalling;
         default: result.status = StatusOff;
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/event_trigger_pulse_repeater.sv
// ---------------------------------------------------------------------------
// Event trigger pulse repeater
// Per-tick event trigger with tap, level and periodic repeat behaviour.
// ---------------------------------------------------------------------------
// One transaction per frame tick, one result transaction per input. Each
// accepted item is evaluated combinationally against the level and repeat
// counter state and its result is held in one output register, so the block
// takes a new item every clock while the result side keeps up; req_tready
// follows rsp_tready whenever the output register is occupied. rsp_tvalid
// rises in the cycle after acceptance. The user must write configuration
// through the csr port only with no transaction outstanding (not enforced).
`default_nettype none

module event_trigger_pulse_repeater
   import etpr_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_we,
   input  wire [CsrAddrWidth-1:0]  csr_addr,
   input  wire [CsrDataWidth-1:0]  csr_wdata,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   // [0] enabled, [1] event_seen, [2] value_nonzero, [7:3] zero
   input  wire [ReqDataWidth-1:0]  req_tdata,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   // [0] fire, [1] catch_up, [2] positive, [4:3] status, [7:5] zero
   output logic [RspDataWidth-1:0] rsp_tdata
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   state_type  state_ff;
   state_type  state_in;
   result_type result_ff;
   result_type step_result;
   item_type   item;
   logic       valid_ff;
   logic       valid_in;
   logic       req_accept;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            RegInvertValue:  cfg_in.invert_value   = csr_wdata[0];
            RegTapMode:      cfg_in.tap_mode       = csr_wdata[0];
            RegLevelMode:    cfg_in.level_mode     = csr_wdata[0];
            RegRepeatOnHigh: cfg_in.repeat_on_high = csr_wdata[0];
            RegRepeatOnLow:  cfg_in.repeat_on_low  = csr_wdata[0];
            RegRepeatPeriod: cfg_in.repeat_period  = csr_wdata[PeriodWidth-1:0];
            default: ;
         endcase
      end
   end

   assign item.enabled       = req_tdata[0];
   assign item.event_seen    = req_tdata[1];
   assign item.value_nonzero = req_tdata[2];

   etpr_step u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .item      (item),
      .state_nxt (state_in),
      .result    (step_result)
   );

   assign req_tready = !valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign valid_in   = req_accept || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '0;
         state_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         cfg_ff   <= cfg_in;
         valid_ff <= valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= step_result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - $bits(result_type)){1'b0}}, result_ff};

   a_accept_gives_result: assert property (
      @(posedge clock) disable iff (reset) req_accept |=> rsp_tvalid)
      else $error("accepted transaction produced no result");

   a_disabled_keeps_state: assert property (
      @(posedge clock) disable iff (reset) (req_accept && !item.enabled) |=> $stable(state_ff))
      else $error("disabled tick changed state");

   a_catch_up_needs_level: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && result_ff.catch_up) |-> (cfg_ff.level_mode && !result_ff.fire))
      else $error("catch-up raised outside level mode or with fire");

   a_tap_low_quiet: assert property (
      @(posedge clock) disable iff (reset)
      (req_accept && item.enabled && cfg_ff.tap_mode && !step_result.fire) |=> !state_ff.level_now)
      else $error("tap mode left level on without firing");

endmodule

`default_nettype wire

// File: tb/sv/event_trigger_pulse_repeater_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Event trigger pulse repeater testbench
// Drives tick transactions through the request stream under several register
// settings and idling patterns. A behavioural predictor computes the expected
// response for each accepted tick; the response stream is checked in order.
// ---------------------------------------------------------------------------
module event_trigger_pulse_repeater_test;
   import etpr_pkg::*;

   localparam logic [CountWidth-1:0] CountTop = '1;
   localparam int WatchdogLimit = 3000;
   localparam int HoldOffCycles = 300;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    csr_we     = 1'b0;
   logic [CsrAddrWidth-1:0] csr_addr   = '0;
   logic [CsrDataWidth-1:0] csr_wdata  = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;

   cfg_type    trig_cfg   = '0;
   state_type  trig_state = '0;
   result_type pending_results[$];

   int error_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_off_left  = 0;
   int quiet_cycles   = 0;

   always #10 clock = ~clock;

   event_trigger_pulse_repeater dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // returns {repeat due, next count}; the count saturates at its top
   function automatic logic [CountWidth:0] count_tick(input logic [CountWidth-1:0] cnt);
      logic [CountWidth-1:0] nxt;
      nxt = (cnt == CountTop) ? cnt : cnt + 1'b1;
      if (32'(nxt) > 32'(trig_cfg.repeat_period))
         return {1'b1, {CountWidth{1'b0}}};
      return {1'b0, nxt};
   endfunction

   function automatic result_type step_trigger(input item_type it);
      result_type          res;
      logic [CountWidth:0] tick;
      res = '0;
      if (it.enabled) begin
         trig_state.level_before = trig_state.level_now;
         trig_state.level_now    = it.value_nonzero ^ trig_cfg.invert_value;
         if (it.event_seen) begin
            if (trig_state.level_now || !trig_cfg.tap_mode) begin
               res.fire = 1'b1;
               trig_state.high_tick_count = '0;
               trig_state.low_tick_count  = '0;
            end
         end else begin
            if (trig_cfg.repeat_on_high) begin
               tick = count_tick(trig_state.high_tick_count);
               trig_state.high_tick_count = tick[CountWidth-1:0];
               if (tick[CountWidth] && trig_state.level_now)
                  res.fire = 1'b1;
            end
            // low repeat is skipped in tap mode
            if (trig_cfg.repeat_on_low && !trig_cfg.tap_mode) begin
               tick = count_tick(trig_state.low_tick_count);
               trig_state.low_tick_count = tick[CountWidth-1:0];
               if (tick[CountWidth] && !trig_state.level_now)
                  res.fire = 1'b1;
            end
         end
         // tap: falling pulse after a positive tick, then level forced off
         if (trig_cfg.tap_mode && !res.fire) begin
            if (trig_state.level_before)
               res.fire = 1'b1;
            trig_state.level_now = 1'b0;
         end
         if (!res.fire && trig_cfg.level_mode)
            res.catch_up = 1'b1;
      end
      res.positive = trig_state.level_now;
      case ({trig_state.level_now, trig_state.level_before})
         2'b10:   res.status = StatusRising;
         2'b11:   res.status = StatusHeld;
         2'b01:   res.status = StatusFalling;
         default: res.status = StatusOff;
      endcase
      return res;
   endfunction

   task automatic write_reg(input logic [CsrAddrWidth-1:0] addr, input int unsigned value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value[CsrDataWidth-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (addr)
         RegInvertValue:  trig_cfg.invert_value   = value[0];
         RegTapMode:      trig_cfg.tap_mode       = value[0];
         RegLevelMode:    trig_cfg.level_mode     = value[0];
         RegRepeatOnHigh: trig_cfg.repeat_on_high = value[0];
         RegRepeatOnLow:  trig_cfg.repeat_on_low  = value[0];
         RegRepeatPeriod: trig_cfg.repeat_period  = value[PeriodWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic write_config(input bit inv, input bit tap, input bit lvl, input bit hi,
                               input bit lo, input int unsigned period);
      write_reg(RegInvertValue, 32'(inv));
      write_reg(RegTapMode, 32'(tap));
      write_reg(RegLevelMode, 32'(lvl));
      write_reg(RegRepeatOnHigh, 32'(hi));
      write_reg(RegRepeatOnLow, 32'(lo));
      write_reg(RegRepeatPeriod, period);
   endtask

   task automatic send_tick(input bit en, input bit ev, input bit nz);
      item_type it;
      it.enabled       = en;
      it.event_seen    = ev;
      it.value_nonzero = nz;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(ReqDataWidth-3){1'b0}}, nz, ev, en};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.insert(pending_results.size(), step_trigger(it));
   endtask

   // sender pauses until every outstanding response has come back
   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_config;
      int unsigned period;
      case ($urandom_range(7))
         0:       period = 0;
         1:       period = 100000;
         2:       period = 32'(CountTop);
         default: period = $urandom_range(1, 4);
      endcase
      write_config(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)), period);
   endtask

   task automatic send_random_tick;
      send_tick($urandom_range(9) != 0, $urandom_range(2) == 0, 1'($urandom_range(1)));
   endtask

   task automatic test_directed;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_config(0, 0, 0, 0, 0, 0);
      send_tick(0, 1, 1);
      send_tick(1, 1, 1);
      send_tick(1, 0, 1);
      send_tick(1, 1, 0);
      drain();
      write_config(1, 0, 1, 0, 0, 0);
      send_tick(1, 0, 0);
      send_tick(1, 1, 1);
      drain();
      // tap with level: suppressed event, repeat fire, falling pulse, catch-up
      write_config(0, 1, 1, 1, 1, 0);
      send_tick(1, 1, 0);
      send_tick(1, 1, 1);
      send_tick(1, 0, 1);
      send_tick(1, 0, 0);
      send_tick(1, 0, 0);
      drain();
      write_config(0, 0, 0, 0, 1, 0);
      send_tick(1, 0, 0);
      send_tick(1, 0, 0);
      send_tick(1, 0, 0);
      send_tick(0, 0, 0);
      drain();
      write_config(0, 0, 0, 1, 1, 2);
      send_tick(1, 0, 1);
      send_tick(1, 0, 1);
      send_tick(1, 0, 1);
      send_tick(1, 0, 0);
      send_tick(1, 0, 0);
      send_tick(1, 1, 0);
      drain();
   endtask

   task automatic test_counter_limits;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_config(0, 0, 1, 1, 0, 100000);
      repeat (6) send_tick(1, 0, 1);
      drain();
      // period at the counter top: the counters climb and never repeat
      write_config(0, 0, 1, 1, 1, 32'(CountTop));
      repeat (6) send_tick(1, 0, 1);
      drain();
      write_reg(RegRepeatPeriod, 5);
      send_tick(1, 0, 1);
      send_tick(1, 0, 0);
      send_tick(1, 1, 0);
      drain();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      repeat (5) begin
         random_config();
         repeat (20) send_random_tick();
         drain();
      end
   endtask

   task automatic test_backpressure;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_config();
      hold_off_left = HoldOffCycles;
      repeat (30) send_random_tick();
      drain();
      repeat (20) send_random_tick();
      drain();
   endtask

   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic report_mismatch(input string field, input int want, input int got);
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response transaction: %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            got  = result_type'(rsp_tdata[$bits(result_type)-1:0]);
            if (got.fire != want.fire)
               report_mismatch("fire", int'(want.fire), int'(got.fire));
            if (got.catch_up != want.catch_up)
               report_mismatch("catch_up", int'(want.catch_up), int'(got.catch_up));
            if (got.positive != want.positive)
               report_mismatch("positive", int'(want.positive), int'(got.positive));
            if (got.status != want.status)
               report_mismatch("status", int'(want.status), int'(got.status));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("event_trigger_pulse_repeater_test NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_counter_limits();
      test_random_traffic(0, 0);
      test_random_traffic(83, 0);
      test_random_traffic(0, 83);
      test_random_traffic(22, 22);
      test_backpressure();
      drain();
      repeat (5) @(posedge clock);
      if (error_count == 0)
         $display("event_trigger_pulse_repeater_test OK");
      else
         $display("event_trigger_pulse_repeater_test NOT OK");
      $finish;
   end

endmodule

// File: filelist.f
hdl/etpr_pkg.sv
hdl/etpr_step.sv
hdl/event_trigger_pulse_repeater.sv
tb/sv/event_trigger_pulse_repeater_test.sv
